// ----- rtl/slrt_pkg.sv -----
// Shared types and constants for the sequence loss and reorder tracker.
`timescale 1ns / 1ps
package slrt_pkg;

  localparam int GAP_BITS = 15;
  localparam logic [GAP_BITS-1:0] MAX_GAP_RESET = 15'd1000;

  // result status codes
  localparam logic [1:0] STAT_ONTIME = 2'd0;
  localparam logic [1:0] STAT_EARLY  = 2'd1;
  localparam logic [1:0] STAT_RECOV  = 2'd2;
  localparam logic [1:0] STAT_UNREAS = 2'd3;

  // statistics counter slots
  localparam int C_RECV  = 0;
  localparam int C_EXP   = 1;
  localparam int C_LOST  = 2;
  localparam int C_EARLY = 3;
  localparam int C_LATE  = 4;
  localparam int C_RECOV = 5;
  localparam int C_UNR   = 6;
  localparam int CNT_NUM = 7;

  typedef struct packed {
    logic [15:0] seq_num;
    logic [15:0] sender_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] seq_diff;
    logic [31:0]        received_count;
    logic [31:0]        expected_count;
    logic [31:0]        lost_count;
    logic [31:0]        early_count;
    logic [31:0]        late_count;
    logic [31:0]        recovered_count;
    logic [31:0]        unreasonable_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_START, ST_CLEAR, ST_IDLE, ST_EVAL, ST_INSERT,
    ST_PRUNE, ST_PROBE, ST_RESOLVE, ST_DONE
  } state_t;

  typedef enum logic [1:0] {WK_CLEAR, WK_INSERT, WK_PRUNE, WK_PROBE} walk_t;

  typedef enum logic [2:0] {OC_SENDER, OC_ONTIME, OC_BAD, OC_EARLY, OC_LATE} outcome_t;

  typedef struct packed {
    logic  load;
    logic  eval;
    logic  walk_start;
    walk_t walk_kind;
    logic  late_resolve;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    outcome_t outcome;
    logic     resync;
    logic     found;
    logic     walk_done;
    logic     prune_need;
  } stat_t;

endpackage

// ----- rtl/slrt_ctrl.sv -----
// Sequencing state machine of the tracker.
`timescale 1ns / 1ps
module slrt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  slrt_pkg::stat_t stat,
  output slrt_pkg::cmd_t  cmd
);
  import slrt_pkg::*;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_START;
      ret_r       <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cmd       = '0;
    cmd.walk_kind = WK_CLEAR;
    in_ready  = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_START: begin
        cmd.walk_start = 1'b1;
        cmd.walk_kind  = WK_CLEAR;
        ret_nxt        = ST_IDLE;
        state_nxt      = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (stat.walk_done) state_nxt = ret_r;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        case (stat.outcome)
          OC_SENDER: begin
            cmd.walk_start = 1'b1;
            cmd.walk_kind  = WK_CLEAR;
            ret_nxt        = ST_EVAL;
            state_nxt      = ST_CLEAR;
          end
          OC_BAD: begin
            if (stat.resync) begin
              cmd.walk_start = 1'b1;
              cmd.walk_kind  = WK_CLEAR;
              ret_nxt        = ST_DONE;
              state_nxt      = ST_CLEAR;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          OC_EARLY: begin
            cmd.walk_start = 1'b1;
            cmd.walk_kind  = WK_INSERT;
            state_nxt      = ST_INSERT;
          end
          OC_LATE: begin
            cmd.walk_start = 1'b1;
            cmd.walk_kind  = WK_PROBE;
            state_nxt      = ST_PROBE;
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_INSERT: begin
        if (stat.walk_done) begin
          if (stat.prune_need) begin
            cmd.walk_start = 1'b1;
            cmd.walk_kind  = WK_PRUNE;
            state_nxt      = ST_PRUNE;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_PRUNE: begin
        if (stat.walk_done) state_nxt = ST_DONE;
      end
      ST_PROBE: begin
        if (stat.walk_done) state_nxt = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        cmd.late_resolve = 1'b1;
        if (!stat.found && stat.resync) begin
          cmd.walk_start = 1'b1;
          cmd.walk_kind  = WK_CLEAR;
          ret_nxt        = ST_DONE;
          state_nxt      = ST_CLEAR;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_START;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/slrt_dp.sv -----
// Datapath of the tracker: classification, counters and the missing-number map.
`timescale 1ns / 1ps
module slrt_dp #(
  parameter int SEQ_BITS     = 16,
  parameter int RESYNC_RUN   = 8,
  parameter int COUNTER_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  slrt_pkg::in_item_t           in_data,
  input  logic                         cfg_we,
  input  logic [slrt_pkg::GAP_BITS-1:0] cfg_data,
  input  slrt_pkg::cmd_t               cmd,
  output slrt_pkg::stat_t              stat,
  output slrt_pkg::out_item_t          out_data
);
  import slrt_pkg::*;

  localparam int SB    = SEQ_BITS;
  localparam int RANGE = 1 << SB;
  localparam int DW    = ((SB > GAP_BITS) ? SB : GAP_BITS) + 2;
  localparam int RB    = $clog2(RESYNC_RUN + 1);
  localparam int CB    = COUNTER_BITS;
  localparam logic signed [DW-1:0] RANGE_S = DW'(RANGE);

  logic [SB-1:0]       seq_r, seq_nxt;
  logic [15:0]         snd_r, snd_nxt;
  logic [GAP_BITS-1:0] max_gap_r, max_gap_nxt;
  logic [SB-1:0]       last_seq_r, last_seq_nxt;
  logic [15:0]         last_sender_r, last_sender_nxt;
  logic [SB-1:0]       last_bad_r, last_bad_nxt;
  logic [RB-1:0]       run_r, run_nxt;
  logic [SB:0]         members_r, members_nxt;
  logic [CB-1:0]       cnt_r [CNT_NUM];
  logic [CB-1:0]       cnt_nxt [CNT_NUM];
  logic [1:0]          status_r, status_nxt;
  logic signed [DW-1:0] diff_r, diff_nxt;
  walk_t               kind_r, kind_nxt;
  logic [SB-1:0]       addr_r, addr_nxt;
  logic [SB:0]         rem_r, rem_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [SB-1:0]       pend_addr_r, pend_addr_nxt;
  logic                found_r, found_nxt;
  logic                rd_r;
  out_item_t           out_r, out_nxt;

  logic                mem [RANGE];
  logic                mem_we;
  logic [SB-1:0]       mem_wa;
  logic                mem_wd;

  // classification
  logic                 recv_nz;
  logic [SB-1:0]        expected;
  logic signed [DW-1:0] inc_s, ex_s, gap_s, ag_s, diff_s;
  logic                 bad_gap;
  outcome_t             outcome;
  logic [CB-1:0]        diff_u;

  // bad-run tracking
  logic [SB-1:0] want;
  logic          bad_match;
  logic [RB-1:0] run_inc;
  logic          resync;
  logic          do_bad;

  // prune window
  logic signed [DW-1:0] cutoff_s, last_s, m_s;
  logic                 drop;

  assign recv_nz  = cnt_r[C_RECV] != '0;
  assign expected = recv_nz ? SB'(last_seq_r + 1'b1) : seq_r;
  assign inc_s    = $signed(DW'(seq_r));
  assign ex_s     = $signed(DW'(expected));
  assign gap_s    = $signed(DW'(max_gap_r));
  assign ag_s     = (inc_s > ex_s) ? inc_s - ex_s : ex_s - inc_s;

  always_comb begin
    bad_gap = 1'b0;
    if (ag_s >= RANGE_S - gap_s) begin
      // gap crosses the wrap point: fold it back
      diff_s = (inc_s > ex_s) ? inc_s - RANGE_S - ex_s : inc_s - ex_s + RANGE_S;
    end else if (ag_s > gap_s) begin
      bad_gap = 1'b1;
      diff_s  = '0;
    end else begin
      diff_s = inc_s - ex_s;
    end
  end

  always_comb begin
    if (snd_r != last_sender_r && recv_nz) outcome = OC_SENDER;
    else if (seq_r == expected)            outcome = OC_ONTIME;
    else if (bad_gap)                      outcome = OC_BAD;
    else if (diff_s > 0)                   outcome = OC_EARLY;
    else                                   outcome = OC_LATE;
  end

  assign diff_u    = CB'($unsigned(diff_s));
  assign want      = (run_r != '0) ? SB'(last_bad_r + 1'b1) : seq_r;
  assign bad_match = seq_r == want;
  assign run_inc   = run_r + 1'b1;
  assign resync    = bad_match && (run_inc >= RB'(RESYNC_RUN));
  assign do_bad    = (cmd.eval && outcome == OC_BAD) || (cmd.late_resolve && !found_r);

  assign last_s   = $signed(DW'(last_seq_r));
  assign cutoff_s = last_s - gap_s;
  assign m_s      = $signed(DW'(pend_addr_r));
  assign drop     = (cutoff_s >= 0) ? (m_s > last_s || m_s < cutoff_s)
                                    : (m_s > last_s && m_s < cutoff_s + RANGE_S);

  always_comb begin
    seq_nxt         = seq_r;
    snd_nxt         = snd_r;
    max_gap_nxt     = max_gap_r;
    last_seq_nxt    = last_seq_r;
    last_sender_nxt = last_sender_r;
    last_bad_nxt    = last_bad_r;
    run_nxt         = run_r;
    members_nxt     = members_r;
    cnt_nxt         = cnt_r;
    status_nxt      = status_r;
    diff_nxt        = diff_r;
    kind_nxt        = kind_r;
    addr_nxt        = addr_r;
    rem_nxt         = rem_r;
    pend_v_nxt      = 1'b0;
    pend_addr_nxt   = pend_addr_r;
    found_nxt       = found_r;
    out_nxt         = out_r;
    mem_we          = 1'b0;
    mem_wa          = pend_addr_r;
    mem_wd          = 1'b0;

    if (cmd.load) begin
      seq_nxt = in_data.seq_num[SB-1:0];
      snd_nxt = in_data.sender_id;
    end
    if (cfg_we) max_gap_nxt = cfg_data;

    if (cmd.eval) begin
      last_sender_nxt = snd_r;
      if (outcome == OC_SENDER) begin
        for (int i = 0; i < CNT_NUM; i++) cnt_nxt[i] = '0;
        run_nxt      = '0;
        last_bad_nxt = '0;
        members_nxt  = '0;
      end else begin
        cnt_nxt[C_RECV] = cnt_r[C_RECV] + CB'(1);
        case (outcome)
          OC_ONTIME: begin
            last_seq_nxt   = seq_r;
            cnt_nxt[C_EXP] = cnt_r[C_EXP] + CB'(1);
            run_nxt        = '0;
            status_nxt     = STAT_ONTIME;
            diff_nxt       = '0;
          end
          OC_BAD: begin
            status_nxt     = STAT_UNREAS;
            diff_nxt       = '0;
            cnt_nxt[C_UNR] = cnt_r[C_UNR] + CB'(1);
          end
          OC_EARLY: begin
            status_nxt       = STAT_EARLY;
            diff_nxt         = diff_s;
            cnt_nxt[C_EARLY] = cnt_r[C_EARLY] + CB'(1);
            cnt_nxt[C_LOST]  = cnt_r[C_LOST] + diff_u;
            cnt_nxt[C_EXP]   = cnt_r[C_EXP] + diff_u + CB'(1);
            last_seq_nxt     = seq_r;
            run_nxt          = '0;
          end
          default: begin
            // late: final status decided after the map probe
            status_nxt      = STAT_UNREAS;
            diff_nxt        = diff_s;
            cnt_nxt[C_LATE] = cnt_r[C_LATE] + CB'(1);
          end
        endcase
      end
    end

    if (cmd.late_resolve) begin
      if (found_r) begin
        status_nxt       = STAT_RECOV;
        cnt_nxt[C_LOST]  = cnt_r[C_LOST] + {CB{1'b1}};
        cnt_nxt[C_RECOV] = cnt_r[C_RECOV] + CB'(1);
        run_nxt          = '0;
      end else begin
        status_nxt     = STAT_UNREAS;
        cnt_nxt[C_UNR] = cnt_r[C_UNR] + CB'(1);
      end
    end

    if (do_bad) begin
      if (!bad_match) begin
        run_nxt = '0;
      end else begin
        run_nxt      = run_inc;
        last_bad_nxt = seq_r;
        if (resync) begin
          last_seq_nxt = seq_r;
          for (int i = 0; i < CNT_NUM; i++) cnt_nxt[i] = '0;
          cnt_nxt[C_RECV] = CB'(RESYNC_RUN);
          cnt_nxt[C_EXP]  = CB'(RESYNC_RUN);
          members_nxt     = '0;
          run_nxt         = '0;
        end
      end
    end

    // map walk: one entry per cycle, the read-modify-write lagging the address by one register
    if (cmd.walk_start) begin
      kind_nxt  = cmd.walk_kind;
      found_nxt = 1'b0;
      case (cmd.walk_kind)
        WK_INSERT: begin
          addr_nxt = expected;
          rem_nxt  = (SB+1)'($unsigned(diff_s));
        end
        WK_PROBE: begin
          addr_nxt = seq_r;
          rem_nxt  = (SB+1)'(1);
        end
        default: begin
          addr_nxt = '0;
          rem_nxt  = (SB+1)'(RANGE);
        end
      endcase
    end else if (rem_r != '0) begin
      addr_nxt = addr_r + 1'b1;
      rem_nxt  = rem_r - 1'b1;
      if (kind_r == WK_CLEAR) begin
        mem_we = 1'b1;
        mem_wa = addr_r;
        mem_wd = 1'b0;
      end else begin
        pend_v_nxt    = 1'b1;
        pend_addr_nxt = addr_r;
      end
    end

    if (pend_v_r) begin
      case (kind_r)
        WK_INSERT: begin
          if (!rd_r) begin
            mem_we      = 1'b1;
            mem_wd      = 1'b1;
            members_nxt = members_r + 1'b1;
          end
        end
        WK_PRUNE: begin
          if (rd_r && drop) begin
            mem_we      = 1'b1;
            members_nxt = members_r - 1'b1;
          end
        end
        WK_PROBE: begin
          if (rd_r) begin
            mem_we      = 1'b1;
            members_nxt = members_r - 1'b1;
            found_nxt   = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (cmd.out_load) begin
      out_nxt.status             = status_r;
      out_nxt.seq_diff           = 16'(diff_r);
      out_nxt.received_count     = 32'(cnt_r[C_RECV]);
      out_nxt.expected_count     = 32'(cnt_r[C_EXP]);
      out_nxt.lost_count         = 32'(cnt_r[C_LOST]);
      out_nxt.early_count        = 32'(cnt_r[C_EARLY]);
      out_nxt.late_count         = 32'(cnt_r[C_LATE]);
      out_nxt.recovered_count    = 32'(cnt_r[C_RECOV]);
      out_nxt.unreasonable_count = 32'(cnt_r[C_UNR]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_gap_r     <= MAX_GAP_RESET;
      last_seq_r    <= '0;
      last_sender_r <= '0;
      last_bad_r    <= '0;
      run_r         <= '0;
      members_r     <= '0;
      for (int i = 0; i < CNT_NUM; i++) cnt_r[i] <= '0;
      kind_r        <= WK_CLEAR;
      rem_r         <= '0;
      pend_v_r      <= 1'b0;
      found_r       <= 1'b0;
    end else begin
      max_gap_r     <= max_gap_nxt;
      last_seq_r    <= last_seq_nxt;
      last_sender_r <= last_sender_nxt;
      last_bad_r    <= last_bad_nxt;
      run_r         <= run_nxt;
      members_r     <= members_nxt;
      cnt_r         <= cnt_nxt;
      kind_r        <= kind_nxt;
      rem_r         <= rem_nxt;
      pend_v_r      <= pend_v_nxt;
      found_r       <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r       <= seq_nxt;
    snd_r       <= snd_nxt;
    status_r    <= status_nxt;
    diff_r      <= diff_nxt;
    addr_r      <= addr_nxt;
    pend_addr_r <= pend_addr_nxt;
    out_r       <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_r <= mem[addr_r];
  end

  assign stat.outcome    = outcome;
  assign stat.resync     = resync;
  assign stat.found      = found_r;
  assign stat.walk_done  = (rem_r == '0) && !pend_v_r;
  assign stat.prune_need = DW'(members_r) > DW'(max_gap_r);
  assign out_data        = out_r;

endmodule

// ----- rtl/sequence_loss_reorder_tracker.sv -----
// Top level of the sequence loss and reorder tracker.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  in_     | input     | in_valid / in_ready   | slrt_pkg::in_item_t
//  out_    | output    | out_valid / out_ready | slrt_pkg::out_item_t
//  cfg_    | input     | cfg_valid / cfg_ready | max_gap, 15 bits
//
// One item at a time. On time or unreasonable: the result is loaded after
// evaluation. Early: the skipped numbers are marked in the map, then the missing
// set is pruned when it holds more than max_gap entries. Late: the map is probed.
// A sender change adds a full map clear, as does a resync. All walks run at one
// map entry per cycle through the single-bit missing map. After reset a
// clearing pass runs with in_ready low; cfg writes are taken at any time.
// A stalled result stays in the output register while the next transfer in
// is accepted.
`timescale 1ns / 1ps
module sequence_loss_reorder_tracker #(
  parameter int SEQ_BITS     = 16,
  parameter int RESYNC_RUN   = 8,
  parameter int COUNTER_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  slrt_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output slrt_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [slrt_pkg::GAP_BITS-1:0] cfg_data
);
  import slrt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // register writes must land only while idle; the user keeps to this, the block does not enforce it, so always ready
  assign cfg_ready = 1'b1;

  slrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  slrt_dp #(
    .SEQ_BITS     (SEQ_BITS),
    .RESYNC_RUN   (RESYNC_RUN),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ----- rtl/slrt_checker.sv -----
// Port-level checks of the tracker and their bind.
`timescale 1ns / 1ps
module slrt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input slrt_pkg::out_item_t out_data
);
  import slrt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input taken during map clear");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while busy");

  a_recov_diff: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STAT_RECOV |-> out_data.seq_diff < 0)
    else $error("recovered result without negative diff");

  a_early_diff: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STAT_EARLY |-> out_data.seq_diff > 0)
    else $error("early result without positive diff");

endmodule

bind sequence_loss_reorder_tracker slrt_checker u_chk (.*);
